/* src/svra_pkg.sv */
// shared types and command codes for the range-add / point-query breakpoint table
// used by svra_cell, svra_chain and step_vector_range_add; no dependencies
package svra_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 2;

  // commands broadcast to every cell of the chain
  localparam logic [CMD_W-1:0] CMD_HOLD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd3;

  // input opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] range_start;
    logic [WORD_W-1:0] range_end;
    logic [WORD_W-1:0] amount;
    logic [WORD_W-1:0] query_pos;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value_out;
    logic              status;
  } rsp_t;

  // broadcast command: key is the compare / insert position, lo the range start
  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] amount;
  } cmd_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    logic              gt;
    logic              valid;
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] val;
  } link_t;

  // registered search flags of one cell
  typedef struct packed {
    logic              eq_key;
    logic              eq_lo;
    logic [WORD_W-1:0] sel_val;
  } flag_t;

  // reduced search result of the whole chain
  typedef struct packed {
    logic              has_key;
    logic              has_lo;
    logic [WORD_W-1:0] value;
  } find_t;

endpackage

/* src/svra_cell.sv */
// one breakpoint cell: holds a position, a value and a valid bit
// talks only to its two neighbors and the broadcast command; uses svra_pkg
module svra_cell (
  input  logic            clk,
  input  logic            rst,
  input  svra_pkg::cmd_t  cmd,
  input  svra_pkg::link_t left,
  input  logic            right_gt,
  output svra_pkg::link_t link,
  output svra_pkg::flag_t flags
);
  import svra_pkg::*;

  logic              valid;
  logic [WORD_W-1:0] pos;
  logic [WORD_W-1:0] val;
  logic              gt;
  logic              in_range;

  // invalid cells count as lying above every key
  assign gt       = !valid || (pos > cmd.key);
  assign in_range = valid && (pos >= cmd.lo) && (pos < cmd.key);

  assign link.gt    = gt;
  assign link.valid = valid;
  assign link.pos   = pos;
  assign link.val   = val;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.code == CMD_INSERT) begin
      if (left.gt) begin
        valid <= left.valid;
      end else if (gt) begin
        valid <= 1'b1;
      end
    end
  end

  // position and value
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_INSERT: begin
        if (left.gt) begin
          pos <= left.pos;
          val <= left.val;
        end else if (gt) begin
          // new breakpoint takes the value of the last one at or below it
          pos <= cmd.key;
          val <= left.val;
        end
      end
      CMD_ADD: begin
        if (in_range) begin
          val <= val + cmd.amount;
        end
      end
      default: begin
      end
    endcase
  end

  // search flags: equality hits and the value if this is the last cell at or below key
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_CHECK) begin
      flags.eq_key  <= valid && (pos == cmd.key);
      flags.eq_lo   <= valid && (pos == cmd.lo);
      flags.sel_val <= (!gt && right_gt) ? val : '0;
    end
  end

endmodule

/* src/svra_chain.sv */
// row of breakpoint cells kept sorted by position, plus the or-reduction of their flags
// instantiates svra_cell; uses svra_pkg
module svra_chain #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  svra_pkg::cmd_t  cmd,
  output svra_pkg::find_t find
);
  import svra_pkg::*;

  link_t links [CAPACITY];
  flag_t flags [CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_in;
    logic  right_gt;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_gt = 1'b1;
    end else begin : g_mid
      assign right_gt = links[i+1].gt;
    end

    svra_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .left     (left_in),
      .right_gt (right_gt),
      .link     (links[i]),
      .flags    (flags[i])
    );
  end

  // reduce registered flags; at most one cell selects a value
  always_comb begin
    find = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      find.has_key = find.has_key | flags[i].eq_key;
      find.has_lo  = find.has_lo  | flags[i].eq_lo;
      find.value   = find.value   | flags[i].sel_val;
    end
  end

endmodule

/* src/step_vector_range_add.sv */
// top level of the range-add / point-query breakpoint table: request control and result register
// instantiates svra_chain; uses svra_pkg
//
//  channel | signals                  | direction | payload
//  req     | req_valid, req_stall     | in        | req_t: opcode, range, amount, query_pos
//  rsp     | rsp_valid, rsp_stall     | out       | rsp_t: value_out, status
//
// one request at a time: a query or an empty or rejected add runs the search pass and then
// loads its result; an add runs the search, one insert pass per new breakpoint and the add pass;
// a new request is taken the cycle after the result loads
// reset empties the table by clearing the cell valid bits.
// a result waits in the output register while rsp_stall is high; the next request
// is taken meanwhile, and its result waits until the register is free.
module step_vector_range_add #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  svra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output svra_pkg::rsp_t rsp
);
  import svra_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ST_W  = 3;

  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_CHECK  = 3'd1;
  localparam logic [ST_W-1:0] S_DECIDE = 3'd2;
  localparam logic [ST_W-1:0] S_INS_E  = 3'd3;
  localparam logic [ST_W-1:0] S_INS_S  = 3'd4;
  localparam logic [ST_W-1:0] S_ADD    = 3'd5;
  localparam logic [ST_W-1:0] S_DONE   = 3'd6;

  logic [ST_W-1:0]  state;
  logic [ST_W-1:0]  state_next;
  logic [CNT_W-1:0] count;
  req_t             item;
  logic             need_s;
  rsp_t             result;
  cmd_t             cmd;
  find_t            find;
  logic [CNT_W:0]   need_total;
  logic             load_rsp;

  assign req_stall = (state != S_IDLE);
  assign load_rsp  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // broadcast command to the cell row
  always_comb begin
    cmd.code   = CMD_HOLD;
    cmd.key    = item.range_end;
    cmd.lo     = item.range_start;
    cmd.amount = item.amount;
    unique case (state)
      S_CHECK: begin
        cmd.code = CMD_CHECK;
        if (item.opcode == OP_QUERY) begin
          cmd.key = item.query_pos;
        end
      end
      S_INS_E: cmd.code = CMD_INSERT;
      S_INS_S: begin
        cmd.code = CMD_INSERT;
        cmd.key  = item.range_start;
      end
      S_ADD:   cmd.code = CMD_ADD;
      default: cmd.code = CMD_HOLD;
    endcase
  end

  svra_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .find (find)
  );

  // fill level after the new breakpoints this add needs
  assign need_total = {1'b0, count}
                    + (CNT_W + 1)'(!find.has_key)
                    + (CNT_W + 1)'(!find.has_lo);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_CHECK;
      S_CHECK:  state_next = S_DECIDE;
      S_DECIDE: begin
        if (item.opcode == OP_QUERY || item.range_start >= item.range_end ||
            need_total > (CNT_W + 1)'(CAPACITY)) begin
          state_next = S_DONE;
        end else if (!find.has_key) begin
          state_next = S_INS_E;
        end else if (!find.has_lo) begin
          state_next = S_INS_S;
        end else begin
          state_next = S_ADD;
        end
      end
      S_INS_E:  state_next = need_s ? S_INS_S : S_ADD;
      S_INS_S:  state_next = S_ADD;
      S_ADD:    state_next = S_DONE;
      S_DONE:   if (load_rsp) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // breakpoint fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_INS_E || state == S_INS_S) begin
      count <= count + CNT_W'(1);
    end
  end

  // request capture and result build
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      item <= req;
    end
    if (state == S_DECIDE) begin
      need_s        <= !find.has_lo;
      result.status <= STAT_OK;
      if (item.opcode == OP_QUERY) begin
        result.value_out <= find.value;
      end else begin
        result.value_out <= '0;
        if (item.range_start < item.range_end &&
            need_total > (CNT_W + 1)'(CAPACITY)) begin
          result.status <= STAT_FULL;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= result;
    end
  end

endmodule
